[hw/rtl/dxt_pkg.sv]
// Shared types and constants for the DXT texture block decoder.
// No dependencies; imported by every module of the block.
package dxt_pkg;

  localparam int OFS_W    = 14;  // texel offset width, wraps modulo 2**OFS_W
  localparam int CFG_IW   = 1;   // configuration register index width
  localparam int CFG_DW   = 13;  // widest configuration register
  localparam int QDEPTH   = 2;   // classified blocks held between front and back

  localparam logic [CFG_IW-1:0] CFG_FORMAT = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_PITCH  = 1'b1;

  localparam logic [1:0] FMT_DXT1 = 2'd0;
  localparam logic [1:0] FMT_DXT3 = 2'd1;

  typedef enum logic [1:0] {
    AM_OPAQUE   = 2'd0,  // DXT1: 255, or 0 on transparent index
    AM_EXPLICIT = 2'd1,  // DXT3: 4-bit alpha replicated
    AM_INTERP   = 2'd2   // DXT5: 8-entry alpha table
  } alpha_mode_t;

  // One classified block as handed from front to back.
  typedef struct packed {
    alpha_mode_t            amode;
    logic                   transp3;   // DXT1 three-color: index 3 is clear black
    logic [3:0][2:0][7:0]   pal;       // [index][channel r,g,b]
    logic [7:0][7:0]        atab;      // DXT5 alpha table
    logic [31:0]            idx_bits;  // 2-bit color indices
    logic [63:0]            lo_bits;   // DXT3 nibbles or DXT5 selectors
    logic [OFS_W-1:0]       pitch;     // clamped pitch modulo 2**OFS_W
  } dxt_blk_t;

  // x / 3 for x <= 765: reciprocal estimate from below, one correction.
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] p;
    logic [9:0]  q;
    logic [9:0]  r;
    p = {10'd0, x} * 20'd341;
    q = p[19:10];
    r = x - 10'(q * 10'd3);
    return (r >= 10'd3) ? 8'(q + 10'd1) : q[7:0];
  endfunction

  // x / 5 for x <= 1275.
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [17:0] p;
    logic [10:0] q;
    logic [10:0] r;
    p = {7'd0, x} * 18'd51;
    q = 11'(p[17:8]);
    r = x - 11'(q * 11'd5);
    return (r >= 11'd5) ? 8'(q + 11'd1) : q[7:0];
  endfunction

  // x / 7 for x <= 1785.
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [17:0] p;
    logic [10:0] q;
    logic [10:0] r;
    p = {7'd0, x} * 18'd73;
    q = 11'(p[17:9]);
    r = x - 11'(q * 11'd7);
    return (r >= 11'd7) ? 8'(q + 11'd1) : q[7:0];
  endfunction

  // RGB565 to 8-bit channels by bit replication.
  function automatic logic [2:0][7:0] widen565(input logic [15:0] c);
    logic [2:0][7:0] w;
    w[0] = {c[15:11], c[15:13]};
    w[1] = {c[10:5], c[10:9]};
    w[2] = {c[4:0], c[4:2]};
    return w;
  endfunction

endpackage

[hw/rtl/dxt_front.sv]
// Front end: configuration registers, block accept and classification.
// Builds the color palette and alpha table; depends on dxt_pkg.
module dxt_front import dxt_pkg::*; #(
  parameter int MAX_ROW_PITCH = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  logic              start,
  input  logic [63:0]       in_block_low,
  input  logic [63:0]       in_block_high,
  input  logic              q_full,
  output logic              q_push,
  output dxt_blk_t          q_wdata
);

  logic [1:0]        fmt_r;
  logic [CFG_DW-1:0] pitch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= FMT_DXT1;
      pitch_r <= CFG_DW'(4);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_FORMAT: fmt_r   <= cfg_wdata[1:0];
        CFG_PITCH:  pitch_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign q_push = start && !q_full;

  logic            dxt1;
  logic            four;
  logic [15:0]     col0, col1;
  logic [2:0][7:0] w0, w1;
  logic [7:0]      a0, a1;
  logic [31:0]     pitch_c;

  always_comb begin
    dxt1 = (fmt_r == FMT_DXT1);
    col0 = dxt1 ? in_block_low[15:0]  : in_block_high[15:0];
    col1 = dxt1 ? in_block_low[31:16] : in_block_high[31:16];
    four = !dxt1 || (col0 > col1);
    w0   = widen565(col0);
    w1   = widen565(col1);
    a0   = in_block_low[7:0];
    a1   = in_block_low[15:8];

    pitch_c = {{(32-CFG_DW){1'b0}}, pitch_r};
    if (pitch_c < 32'd4)
      pitch_c = 32'd4;
    if (pitch_c > 32'(MAX_ROW_PITCH))
      pitch_c = 32'(MAX_ROW_PITCH);

    q_wdata.pal[0] = w0;
    q_wdata.pal[1] = w1;
    for (int ch = 0; ch < 3; ch++) begin
      if (four) begin
        q_wdata.pal[2][ch] = div3(10'({w0[ch], 1'b0}) + 10'(w1[ch]));
        q_wdata.pal[3][ch] = div3(10'(w0[ch]) + 10'({w1[ch], 1'b0}));
      end else begin
        q_wdata.pal[2][ch] = 8'((9'(w0[ch]) + 9'(w1[ch])) >> 1);
        q_wdata.pal[3][ch] = 8'd0;
      end
    end

    q_wdata.atab[0] = a0;
    q_wdata.atab[1] = a1;
    for (int k = 2; k < 8; k++) begin
      if (a0 > a1)
        q_wdata.atab[k] = div7(11'((8 - k) * a0) + 11'((k - 1) * a1));
      else if (k < 6)
        q_wdata.atab[k] = div5(11'((6 - k) * a0) + 11'((k - 1) * a1));
      else if (k == 6)
        q_wdata.atab[k] = 8'd0;
      else
        q_wdata.atab[k] = 8'd255;
    end

    if (dxt1)
      q_wdata.amode = AM_OPAQUE;
    else if (fmt_r == FMT_DXT3)
      q_wdata.amode = AM_EXPLICIT;
    else
      q_wdata.amode = AM_INTERP;  // format code 3 decodes as DXT5

    q_wdata.transp3  = dxt1 && !four;
    q_wdata.idx_bits = dxt1 ? in_block_low[63:32] : in_block_high[63:32];
    q_wdata.lo_bits  = in_block_low;
    q_wdata.pitch    = pitch_c[OFS_W-1:0];
  end

endmodule

[hw/rtl/dxt_queue.sv]
// Short FIFO of classified blocks between front and back.
// Depth from dxt_pkg::QDEPTH; depends on dxt_pkg.
module dxt_queue import dxt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  dxt_blk_t wdata,
  input  logic     pop,
  output logic     full,
  output logic     not_empty,
  output dxt_blk_t rdata
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  dxt_blk_t        mem_r [QDEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign full      = (cnt_r == CW'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign rdata     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push)
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    if (pop)
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    if (push && !pop)
      cnt_nxt = cnt_r + CW'(1);
    else if (pop && !push)
      cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push)
      mem_r[wr_ptr_r] <= wdata;
  end

endmodule

[hw/rtl/dxt_back.sv]
// Back end: texel sequencer, one texel per cycle in raster order.
// Pops classified blocks from dxt_queue; depends on dxt_pkg.
module dxt_back import dxt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_not_empty,
  input  dxt_blk_t         q_rdata,
  output logic             q_pop,
  output logic             active,
  output logic             out_valid,
  output logic [OFS_W-1:0] out_texel_offset,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic [7:0]       out_alpha,
  output logic             out_last_texel
);

  dxt_blk_t         cur_r;
  logic             active_r;
  logic [3:0]       cnt_r;
  logic [OFS_W-1:0] row_r;

  logic             last;
  logic             load;
  logic [1:0]       ci;
  logic [3:0]       nib;
  logic [5:0]       sh;
  logic [2:0]       sel;
  logic [7:0]       r_c, g_c, b_c, a_c;

  assign active = active_r;
  assign last   = (cnt_r == 4'd15);
  assign load   = q_not_empty && (!active_r || last);
  assign q_pop  = load;

  always_comb begin
    ci  = 2'(cur_r.idx_bits >> {cnt_r, 1'b0});
    nib = 4'(cur_r.lo_bits >> {cnt_r, 2'b00});
    sh  = 6'd16 + {2'b00, cnt_r} + {1'b0, cnt_r, 1'b0};
    sel = 3'(cur_r.lo_bits >> sh);
    r_c = cur_r.pal[ci][0];
    g_c = cur_r.pal[ci][1];
    b_c = cur_r.pal[ci][2];
    case (cur_r.amode)
      AM_OPAQUE:   a_c = (cur_r.transp3 && ci == 2'd3) ? 8'd0 : 8'd255;
      AM_EXPLICIT: a_c = {nib, nib};
      AM_INTERP:   a_c = cur_r.atab[sel];
      default:     a_c = 8'd255;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      cnt_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= active_r;
      if (load) begin
        active_r <= 1'b1;
        cnt_r    <= '0;
      end else if (active_r && last) begin
        active_r <= 1'b0;
      end else if (active_r) begin
        cnt_r <= cnt_r + 4'd1;
      end
    end
  end

  // Row base steps by the pitch after the fourth texel of each row.
  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= q_rdata;
      row_r <= '0;
    end else if (active_r && cnt_r[1:0] == 2'd3) begin
      row_r <= row_r + cur_r.pitch;
    end
    out_texel_offset <= row_r + OFS_W'(cnt_r[1:0]);
    out_red          <= r_c;
    out_green        <= g_c;
    out_blue         <= b_c;
    out_alpha        <= a_c;
    out_last_texel   <= last;
  end

endmodule

[hw/rtl/dxt_texture_block_decoder.sv]
// Top level of the DXT1/DXT3/DXT5 texture block decoder.
// Ties dxt_front, dxt_queue and dxt_back together; depends on dxt_pkg.
//
//   channel  | ports                                      | handshake
//   ---------+--------------------------------------------+------------------------
//   input    | in_block_low, in_block_high                | start && !busy
//   result   | out_texel_offset, out_red/green/blue/alpha,| out_valid, one cycle,
//            | out_last_texel                             | no backpressure
//   config   | cfg_addr, cfg_wdata                        | cfg_we
//
// A block yields 16 texels on consecutive cycles; the back sequencer emits one
// texel per cycle, and a queued block follows the last texel without a gap.
// A block goes through the queue and the back block register to the output registers.
// busy is high while the two-entry block queue is full.
// rst_n is synchronous, active low; it clears the queue and the sequencer.
// The receiver cannot stall: results are shown for exactly one cycle.
module dxt_texture_block_decoder import dxt_pkg::*; #(
  parameter int MAX_ROW_PITCH = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  logic              start,
  output logic              busy,
  input  logic [63:0]       in_block_low,
  input  logic [63:0]       in_block_high,
  output logic              out_valid,
  output logic [OFS_W-1:0]  out_texel_offset,
  output logic [7:0]        out_red,
  output logic [7:0]        out_green,
  output logic [7:0]        out_blue,
  output logic [7:0]        out_alpha,
  output logic              out_last_texel
);

  logic     q_push, q_pop, q_full, q_not_empty, back_active;
  dxt_blk_t q_wdata, q_rdata;

  assign busy = q_full;

  dxt_front #(.MAX_ROW_PITCH(MAX_ROW_PITCH)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .start         (start),
    .in_block_low  (in_block_low),
    .in_block_high (in_block_high),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  dxt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  dxt_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (q_not_empty),
    .q_rdata          (q_rdata),
    .q_pop            (q_pop),
    .active           (back_active),
    .out_valid        (out_valid),
    .out_texel_offset (out_texel_offset),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha),
    .out_last_texel   (out_last_texel)
  );

`ifndef ASSERT_OFF
  // A block's texels come out without gaps.
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_texel |=> out_valid)
    else $error("texel burst broken before last texel");

  // Every block starts at offset zero.
  a_first_ofs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (!$past(out_valid) || $past(out_valid && out_last_texel))
      |-> out_texel_offset == '0)
    else $error("first texel of block not at offset zero");

  // A full queue means the sequencer is draining.
  a_full_active: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> back_active)
    else $error("queue full while sequencer idle");

  // Sequencer only idles when nothing is waiting.
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    q_not_empty && !back_active |-> q_pop)
    else $error("pending block not taken by idle sequencer");
`endif

endmodule
